@@ hw/rtl/first_fit_page_allocator_defines.svh @@
// ---------------------------------------------------------------------------
// first_fit_page_allocator_defines
// assertion macros shared by the page allocator rtl
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FFPA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FFPA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ffpa_pkg.sv @@
// ---------------------------------------------------------------------------
// ffpa_pkg
// types, codes and microcode for the first-fit page allocator
// ---------------------------------------------------------------------------
package ffpa_pkg;

    // field widths
    localparam int PAGE_W    = 12;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W    = 32;
    localparam int WORD_LG   = 5;
    localparam int MAX_PAGES = 4096;
    localparam int PAGE_COUNT_DEF = 4096;
    localparam int STEP_W    = 4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd2;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_END    = 2'd2;

    // configuration reset values
    localparam logic [PAGE_W-1:0] FIRST_FREE_RST = 12'd1;
    localparam logic [PAGE_W-1:0] RSV_START_RST  = 12'd4095;
    localparam logic [PAGE_W-1:0] RSV_END_RST    = 12'd4095;

    // microprogram step addresses
    localparam logic [STEP_W-1:0] STEP_CLEAR    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DECODE   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_START    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_READ     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SCAN     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_NEXT     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_NO_FREE  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FREE_CHK = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FREE_RD  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_FREE_UPD = 4'd10;
    localparam logic [STEP_W-1:0] STEP_BAD_FREE = 4'd11;
    localparam logic [STEP_W-1:0] STEP_RESULT   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_DONE     = 4'd13;

    // datapath action of one step
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_CLEAR,
        ACT_ACCEPT,
        ACT_READ,
        ACT_SCAN,
        ACT_NEXT_ROW,
        ACT_FREE,
        ACT_NO_FREE,
        ACT_BAD_FREE,
        ACT_LOAD_OUT
    } act_t;

    // jump condition of one step
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_CLEARING,
        COND_NO_INPUT,
        COND_IS_FREE,
        COND_START_OUT,
        COND_HIT,
        COND_MORE_ROWS,
        COND_FREE_BAD,
        COND_OUT_BUSY
    } cond_t;

    // control word
    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    // microprogram rom
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{act: ACT_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (step)
            STEP_CLEAR:    w = '{act: ACT_CLEAR,    cond: COND_CLEARING,  target: STEP_CLEAR};
            STEP_IDLE:     w = '{act: ACT_ACCEPT,   cond: COND_NO_INPUT,  target: STEP_IDLE};
            STEP_DECODE:   w = '{act: ACT_NOP,      cond: COND_IS_FREE,   target: STEP_FREE_CHK};
            STEP_START:    w = '{act: ACT_NOP,      cond: COND_START_OUT, target: STEP_NO_FREE};
            STEP_READ:     w = '{act: ACT_READ,     cond: COND_NEVER,     target: STEP_READ};
            STEP_SCAN:     w = '{act: ACT_SCAN,     cond: COND_HIT,       target: STEP_RESULT};
            STEP_NEXT:     w = '{act: ACT_NEXT_ROW, cond: COND_MORE_ROWS, target: STEP_READ};
            STEP_NO_FREE:  w = '{act: ACT_NO_FREE,  cond: COND_ALWAYS,    target: STEP_RESULT};
            STEP_FREE_CHK: w = '{act: ACT_NOP,      cond: COND_FREE_BAD,  target: STEP_BAD_FREE};
            STEP_FREE_RD:  w = '{act: ACT_READ,     cond: COND_NEVER,     target: STEP_FREE_RD};
            STEP_FREE_UPD: w = '{act: ACT_FREE,     cond: COND_ALWAYS,    target: STEP_RESULT};
            STEP_BAD_FREE: w = '{act: ACT_BAD_FREE, cond: COND_NEVER,     target: STEP_BAD_FREE};
            STEP_RESULT:   w = '{act: ACT_LOAD_OUT, cond: COND_OUT_BUSY,  target: STEP_RESULT};
            STEP_DONE:     w = '{act: ACT_NOP,      cond: COND_ALWAYS,    target: STEP_IDLE};
            default:       w = '{act: ACT_NOP,      cond: COND_ALWAYS,    target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/first_fit_page_allocator.sv @@
// sequence: a free is range-checked, then reads its bitmap word and clears the page's bit,
//   or goes straight to the result when rejected; an allocate scans the 32-page bitmap words
//   from the row of first_free_page until one grants, else reports no free page
// throughput: one request at a time, taken again once the result loads and the sequencer is
//   back in idle; the result register lets it in while the previous result waits on m_tready
// reset: synchronous active-low aresetn, then a pass clearing the ceil(min(PAGE_COUNT,4096)/32)
//   bitmap words (128 by default) with s_tready low; configuration writes are taken throughout
// ---------------------------------------------------------------------------
// first_fit_page_allocator
// first-fit bitmap page allocator driven by a small microcoded sequencer
// ---------------------------------------------------------------------------
`include "first_fit_page_allocator_defines.svh"

module first_fit_page_allocator #(
    parameter int PAGE_COUNT = ffpa_pkg::PAGE_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [11:0] page_index
    input  logic                            s_tuser,   // [0] opcode
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [1:0] status, [13:2] granted_page
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffpa_pkg::PAGE_W-1:0]     cfg_data
);
    import ffpa_pkg::*;

    localparam int MAP_PAGES = (PAGE_COUNT < MAX_PAGES) ? PAGE_COUNT : MAX_PAGES;
    localparam int ROWS      = (MAP_PAGES + WORD_W - 1) / WORD_W;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [PAGE_W:0]   PAGE_LIM = (PAGE_W + 1)'(MAP_PAGES);
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    // configuration registers
    logic [PAGE_W-1:0] first_free_reg, rsv_start_reg, rsv_end_reg;

    // sequencer
    logic [STEP_W-1:0] pc_reg, pc_next;
    uword_t            uw;
    logic              cond_true;

    // request and result registers
    logic              in_op_reg;
    logic [PAGE_W-1:0] in_page_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [PAGE_W-1:0] m_page_reg;

    // bitmap memory
    logic [WORD_W-1:0] map_mem [ROWS];
    logic [WORD_W-1:0] rd_word_reg;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic              mem_we, mem_re;
    logic [WORD_W-1:0] mem_wdata;

    // datapath helpers
    logic              in_xfer, out_busy, load_out;
    logic [PAGE_W-1:0] ffp_row_full, page_row_full;
    logic [WORD_W-1:0] avail;
    logic [WORD_LG-1:0] hit_idx;
    logic              scan_hit;
    logic [PAGE_W-1:0] scan_page;
    logic [WORD_W-1:0] scan_word, free_word;
    logic              free_bit, free_bad, start_out;

    function automatic logic [PAGE_W:0] bit_page(input logic [ROW_AW-1:0] r,
                                                 input logic [WORD_LG-1:0] b);
        return ((PAGE_W + 1)'(r) << WORD_LG) | (PAGE_W + 1)'(b);
    endfunction

    function automatic logic in_rsv(input logic [PAGE_W:0] pg,
                                    input logic [PAGE_W-1:0] rs,
                                    input logic [PAGE_W-1:0] re);
        return (rs <= re) && (pg >= {1'b0, rs}) && (pg <= {1'b0, re});
    endfunction

    // configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_free_reg <= FIRST_FREE_RST;
            rsv_start_reg  <= RSV_START_RST;
            rsv_end_reg    <= RSV_END_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FIRST_FREE: first_free_reg <= cfg_data;
                CFG_RSV_START:  rsv_start_reg  <= cfg_data;
                CFG_RSV_END:    rsv_end_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // control word fetch
    assign uw = ucode_rom(pc_reg);

    assign s_tready = (uw.act == ACT_ACCEPT);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign load_out = (uw.act == ACT_LOAD_OUT) && !out_busy;

    // scan of the current bitmap word
    always_comb begin
        avail = '0;
        for (int b = 0; b < WORD_W; b++) begin
            avail[b] = !rd_word_reg[b]
                && (bit_page(row_reg, WORD_LG'(b)) >= {1'b0, first_free_reg})
                && (bit_page(row_reg, WORD_LG'(b)) < PAGE_LIM)
                && !in_rsv(bit_page(row_reg, WORD_LG'(b)), rsv_start_reg, rsv_end_reg);
        end
    end

    // lowest free bit
    always_comb begin
        hit_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (avail[b]) begin
                hit_idx = WORD_LG'(b);
            end
        end
    end

    assign scan_hit  = |avail;
    assign scan_page = PAGE_W'(bit_page(row_reg, hit_idx));
    assign scan_word = rd_word_reg | (WORD_W'(1) << hit_idx);

    // free checks
    assign free_bit  = rd_word_reg[in_page_reg[WORD_LG-1:0]];
    assign free_word = rd_word_reg & ~(WORD_W'(1) << in_page_reg[WORD_LG-1:0]);
    assign free_bad  = ({1'b0, in_page_reg} >= PAGE_LIM)
                    || (in_page_reg < first_free_reg)
                    || in_rsv({1'b0, in_page_reg}, rsv_start_reg, rsv_end_reg);
    assign start_out = ({1'b0, first_free_reg} >= PAGE_LIM);

    assign ffp_row_full  = first_free_reg >> WORD_LG;
    assign page_row_full = s_tdata[PAGE_W-1:0] >> WORD_LG;

    // jump condition
    always_comb begin
        unique case (uw.cond)
            COND_NEVER:     cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_CLEARING:  cond_true = (row_reg != LAST_ROW);
            COND_NO_INPUT:  cond_true = !s_tvalid;
            COND_IS_FREE:   cond_true = (in_op_reg == OP_FREE);
            COND_START_OUT: cond_true = start_out;
            COND_HIT:       cond_true = scan_hit;
            COND_MORE_ROWS: cond_true = (row_reg != LAST_ROW);
            COND_FREE_BAD:  cond_true = free_bad;
            COND_OUT_BUSY:  cond_true = out_busy;
            default:        cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        pc_next = cond_true ? uw.target : pc_reg + 1'b1;
    end

    // datapath controls decoded from the action
    always_comb begin
        row_next        = row_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wdata       = '0;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        unique case (uw.act)
            ACT_NOP: ;
            ACT_CLEAR: begin
                mem_we   = 1'b1;
                row_next = row_reg + 1'b1;
            end
            ACT_ACCEPT: begin
                if (in_xfer) begin
                    row_next = (s_tuser == OP_FREE) ? page_row_full[ROW_AW-1:0]
                                                    : ffp_row_full[ROW_AW-1:0];
                end
            end
            ACT_READ: mem_re = 1'b1;
            ACT_SCAN: begin
                if (scan_hit) begin
                    mem_we          = 1'b1;
                    mem_wdata       = scan_word;
                    res_status_next = ST_OK;
                    res_page_next   = scan_page;
                end
            end
            ACT_NEXT_ROW: row_next = row_reg + 1'b1;
            ACT_FREE: begin
                if (free_bit) begin
                    mem_we          = 1'b1;
                    mem_wdata       = free_word;
                    res_status_next = ST_OK;
                    res_page_next   = in_page_reg;
                end else begin
                    res_status_next = ST_NOT_ALLOCATED;
                    res_page_next   = '0;
                end
            end
            ACT_NO_FREE: begin
                res_status_next = ST_NO_FREE;
                res_page_next   = '0;
            end
            ACT_BAD_FREE: begin
                res_status_next = ST_NOT_ALLOCATED;
                res_page_next   = '0;
            end
            ACT_LOAD_OUT: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= STEP_CLEAR;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_op_reg   <= s_tuser;
            in_page_reg <= s_tdata[PAGE_W-1:0];
        end
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        if (load_out) begin
            m_status_reg <= res_status_reg;
            m_page_reg   <= res_page_reg;
        end
    end

    // bitmap memory ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[row_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_word_reg <= map_mem[row_reg];
        end
    end

    // result channel
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_page_reg, m_status_reg};

    // checks
    `FFPA_ASSERT_IMP(a_no_write_idle, aclk, aresetn, pc_reg == STEP_IDLE, !mem_we, "bitmap written while idle")
    `FFPA_ASSERT_IMP(a_load_free_slot, aclk, aresetn, load_out, !m_tvalid_reg || m_tready, "result overwritten")
    `FFPA_ASSERT_IMP(a_grant_legal, aclk, aresetn, uw.act == ACT_SCAN && scan_hit, (scan_page >= first_free_reg) && !in_rsv({1'b0, scan_page}, rsv_start_reg, rsv_end_reg), "granted page below floor or reserved")
    `FFPA_ASSERT_NXT(a_accept_decodes, aclk, aresetn, in_xfer, pc_reg == STEP_DECODE, "request not decoded after transfer")

endmodule
